// ----- design/assert_macros.svh -----
// Assertion helpers used by vector_angle_and_distance_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define VAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/vad_pkg.sv -----
package vad_pkg;

    localparam int COORD_BITS   = 24;
    localparam int CORDIC_STEPS = 20;
    localparam int PRE_SHIFT    = 60 - COORD_BITS;
    localparam int DEG_FRAC     = 16;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int ABS_W  = COORD_BITS + 1;
    localparam int CX_W   = 64;
    localparam int Z_W    = 25;
    localparam int A_W    = 25;

    localparam int SQ_W       = 2 * ABS_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int RAD_W      = SUM_W + (SUM_W % 2);
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int REM_W      = ROOT_W + 2;

    localparam int NSTG = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

    localparam int ANG_W   = 17;
    localparam int DIST_W  = 26;
    localparam int SAT_EXP = 26;

    localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((ANG_W + DIST_W + 7) / 8) * 8;

    localparam logic [DIST_W-1:0] DIST_MAX    = '1;
    localparam logic [ANG_W-1:0]  ANG_0       = '0;
    localparam logic [ANG_W-1:0]  ANG_90      = ANG_W'(90 * 256);
    localparam logic [ANG_W-1:0]  ANG_180     = ANG_W'(180 * 256);
    localparam logic [ANG_W-1:0]  ANG_270     = ANG_W'(270 * 256);
    localparam logic [ANG_W-1:0]  FULL_CIRCLE = ANG_W'(360 * 256);

    localparam logic signed [Z_W-1:0] Z_MAX = Z_W'(90 << DEG_FRAC);
    localparam logic [A_W-1:0]        A_180 = A_W'(180 << DEG_FRAC);
    localparam logic [A_W-1:0]        A_360 = A_W'(360 << DEG_FRAC);

    typedef struct packed {
        logic dx_neg;
        logic dx_zero;
        logic dy_neg;
        logic dy_zero;
        logic sat;
    } vad_flags_t;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [RAD_W-1:0]       rad;
        logic [REM_W-1:0]       rem;
        logic [ROOT_W-1:0]      root;
        vad_flags_t             flags;
    } vad_stage_t;

    // atan(2^-k) in degrees with 16 fraction bits.
    function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] k);
        logic signed [Z_W-1:0] v;
        case (k)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            5'd20:   v = 25'sd4;
            5'd21:   v = 25'sd2;
            5'd22:   v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/vector_angle_and_distance_top.sv -----
// The pipeline depth from the input transfer to m_axis_tvalid is set by the 26 one-bit
// square root stages that run beside CORDIC. A stalled output is absorbed by a skid register.
// Throughput: one item per clock cycle while the skid register is empty.
// Reset: rst_n asynchronously clears only the valid bits; no clearing pass is needed.
`include "assert_macros.svh"

module vector_angle_and_distance_top (
    input  logic                       clk,
    input  logic                       rst_n,
    // Input stream, one point pair per transfer.
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0 up: origin_x, origin_y, point_x, point_y (signed Q16.8 each).
    input  logic [vad_pkg::IN_W-1:0]   s_axis_tdata,
    // Output stream, one result per input item.
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // Fields from bit 0 up: angle_deg (unsigned Q9.8), distance (unsigned Q18.8), zero fill.
    output logic [vad_pkg::OUT_W-1:0]  m_axis_tdata
);
    import vad_pkg::*;

    // The whole pipeline advances together. It stalls only when the skid register is
    // full, so the ready toward the source is a plain register output.
    logic adv;

    logic signed [COORD_BITS-1:0] in_ox, in_oy, in_px, in_py;

    // Stage P0: differences. The y axis is flipped so that up is positive.
    logic                     p0_valid_reg;
    logic signed [DIFF_W-1:0] p0_dx_reg, p0_dy_reg;
    logic signed [DIFF_W-1:0] p0_dx_next, p0_dy_next;

    // Stage P1: magnitudes and sign, zero and saturation flags.
    logic             p1_valid_reg;
    logic [ABS_W-1:0] p1_ax_reg, p1_ay_reg, p1_ax_next, p1_ay_next;
    vad_flags_t       p1_flags_reg, p1_flags_next;

    // Stage P2: squares for the length.
    logic             p2_valid_reg;
    logic [ABS_W-1:0] p2_ax_reg, p2_ay_reg;
    logic [SQ_W-1:0]  p2_sqx_reg, p2_sqy_reg, p2_sqx_next, p2_sqy_next;
    vad_flags_t       p2_flags_reg;

    // Iteration stages: CORDIC vectoring and digit-by-digit square root side by side.
    vad_stage_t st_reg       [0:NSTG];
    logic       st_valid_reg [0:NSTG];
    vad_stage_t st0_next;
    vad_stage_t st_next      [1:NSTG];

    // Stage F1: rounded length, clamped first-quadrant angle mirrored into its quadrant.
    logic              f1_valid_reg;
    logic [A_W-1:0]    f1_a_reg, f1_a_next;
    logic [DIST_W-1:0] f1_dist_reg, f1_dist_next;
    vad_flags_t        f1_flags_reg;
    vad_stage_t        last_st;
    logic              round_up;
    logic [ROOT_W:0]   root_rnd;
    logic signed [Z_W-1:0] z_clamped;
    logic [A_W-1:0]    t_q1;

    // Stage F2: angle rounded to 8 fraction bits, wrapped, special cases applied.
    logic              f2_valid_reg;
    logic [ANG_W-1:0]  f2_ang_reg, f2_ang_next;
    logic [DIST_W-1:0] f2_dist_reg;
    logic [A_W-8:0]    ang_rnd;
    logic [A_W-8:0]    ang_wrap;

    // Output register and skid register.
    logic              out_valid_reg, out_valid_next;
    logic [ANG_W-1:0]  out_ang_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic              skid_valid_reg, skid_valid_next;
    logic [ANG_W-1:0]  skid_ang_reg;
    logic [DIST_W-1:0] skid_dist_reg;
    logic              take_out, out_load, out_from_skid, skid_load;

    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;

    assign in_ox = s_axis_tdata[0 * COORD_BITS +: COORD_BITS];
    assign in_oy = s_axis_tdata[1 * COORD_BITS +: COORD_BITS];
    assign in_px = s_axis_tdata[2 * COORD_BITS +: COORD_BITS];
    assign in_py = s_axis_tdata[3 * COORD_BITS +: COORD_BITS];

    // ---------------------------------------------------------------- front stages
    always_comb
    begin
        p0_dx_next = DIFF_W'(in_px) - DIFF_W'(in_ox);
        p0_dy_next = DIFF_W'(in_oy) - DIFF_W'(in_py);
    end

    always_comb
    begin
        p1_ax_next = p0_dx_reg[DIFF_W-1] ? ABS_W'(-p0_dx_reg) : ABS_W'(p0_dx_reg);
        p1_ay_next = p0_dy_reg[DIFF_W-1] ? ABS_W'(-p0_dy_reg) : ABS_W'(p0_dy_reg);
        p1_flags_next.dx_neg  = p0_dx_reg[DIFF_W-1];
        p1_flags_next.dx_zero = (p0_dx_reg == '0);
        p1_flags_next.dy_neg  = p0_dy_reg[DIFF_W-1];
        p1_flags_next.dy_zero = (p0_dy_reg == '0);
        // Lengths whose components reach 2^26 saturate; only possible with wide coordinates.
        p1_flags_next.sat = (64'(p1_ax_next) >= (64'(1) << SAT_EXP))
                         || (64'(p1_ay_next) >= (64'(1) << SAT_EXP));
    end

    always_comb
    begin
        p2_sqx_next = SQ_W'(p1_ax_reg) * SQ_W'(p1_ax_reg);
        p2_sqy_next = SQ_W'(p1_ay_reg) * SQ_W'(p1_ay_reg);
    end

    always_comb
    begin
        st0_next.x     = $signed(CX_W'(p2_ax_reg) << PRE_SHIFT);
        st0_next.y     = $signed(CX_W'(p2_ay_reg) << PRE_SHIFT);
        st0_next.z     = '0;
        st0_next.rad   = RAD_W'(SUM_W'(p2_sqx_reg) + SUM_W'(p2_sqy_reg));
        st0_next.rem   = '0;
        st0_next.root  = '0;
        st0_next.flags = p2_flags_reg;
    end

    // ---------------------------------------------------------------- iteration stages
    for (genvar k = 0; k < NSTG; k++)
    begin : g_step
        logic signed [CX_W-1:0] xc, yc, xs, ys;
        logic signed [Z_W-1:0]  zc;
        logic [REM_W-1:0]       rem_sh, trial;

        assign xc     = st_reg[k].x;
        assign yc     = st_reg[k].y;
        assign zc     = st_reg[k].z;
        assign xs     = xc >>> k;
        assign ys     = yc >>> k;
        assign rem_sh = {st_reg[k].rem[REM_W-3:0], st_reg[k].rad[RAD_W-1 -: 2]};
        assign trial  = {st_reg[k].root, 2'b01};

        always_comb
        begin
            st_next[k+1] = st_reg[k];
            if (k < CORDIC_STEPS)
            begin
                // Rotate toward the x axis; y equal to zero takes the counterclockwise branch.
                if (yc > 0)
                begin
                    st_next[k+1].x = xc + ys;
                    st_next[k+1].y = yc - xs;
                    st_next[k+1].z = zc + atan_deg(5'(k));
                end
                else
                begin
                    st_next[k+1].x = xc - ys;
                    st_next[k+1].y = yc + xs;
                    st_next[k+1].z = zc - atan_deg(5'(k));
                end
            end
            if (k < SQRT_STEPS)
            begin
                st_next[k+1].rad = {st_reg[k].rad[RAD_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    st_next[k+1].rem  = rem_sh - trial;
                    st_next[k+1].root = {st_reg[k].root[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    st_next[k+1].rem  = rem_sh;
                    st_next[k+1].root = {st_reg[k].root[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------------------------------------------------------- final stages
    assign last_st = st_reg[NSTG];

    always_comb
    begin
        // Round the length to nearest: up when the remainder exceeds the root.
        round_up = (last_st.rem > REM_W'(last_st.root));
        root_rnd = (ROOT_W + 1)'(last_st.root) + (ROOT_W + 1)'(round_up);
        if (last_st.flags.sat || (64'(root_rnd) > 64'(DIST_MAX)))
        begin
            f1_dist_next = DIST_MAX;
        end
        else
        begin
            f1_dist_next = DIST_W'(root_rnd);
        end

        if (last_st.z < 0)
        begin
            z_clamped = '0;
        end
        else if (last_st.z > Z_MAX)
        begin
            z_clamped = Z_MAX;
        end
        else
        begin
            z_clamped = last_st.z;
        end
        t_q1 = A_W'(z_clamped);

        if (!last_st.flags.dx_neg && !last_st.flags.dy_neg)
        begin
            f1_a_next = t_q1;
        end
        else if (last_st.flags.dx_neg && !last_st.flags.dy_neg)
        begin
            f1_a_next = A_180 - t_q1;
        end
        else if (last_st.flags.dx_neg)
        begin
            f1_a_next = A_180 + t_q1;
        end
        else
        begin
            f1_a_next = A_360 - t_q1;
        end
    end

    always_comb
    begin
        ang_rnd = (A_W - 7)'(((A_W + 1)'(f1_a_reg) + (A_W + 1)'(128)) >> 8);
        if (ang_rnd >= (A_W - 7)'(FULL_CIRCLE))
        begin
            ang_wrap = ang_rnd - (A_W - 7)'(FULL_CIRCLE);
        end
        else
        begin
            ang_wrap = ang_rnd;
        end

        // Axis-aligned and zero vectors take fixed angles.
        if (f1_flags_reg.dx_zero)
        begin
            if (f1_flags_reg.dy_zero)
            begin
                f2_ang_next = ANG_0;
            end
            else if (f1_flags_reg.dy_neg)
            begin
                f2_ang_next = ANG_270;
            end
            else
            begin
                f2_ang_next = ANG_90;
            end
        end
        else if (f1_flags_reg.dy_zero)
        begin
            f2_ang_next = f1_flags_reg.dx_neg ? ANG_180 : ANG_0;
        end
        else
        begin
            f2_ang_next = ANG_W'(ang_wrap);
        end
    end

    // ---------------------------------------------------------------- pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            for (int i = 0; i <= NSTG; i++)
            begin
                st_valid_reg[i] <= 1'b0;
            end
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p0_valid_reg    <= s_axis_tvalid;
            p1_valid_reg    <= p0_valid_reg;
            p2_valid_reg    <= p1_valid_reg;
            st_valid_reg[0] <= p2_valid_reg;
            for (int i = 1; i <= NSTG; i++)
            begin
                st_valid_reg[i] <= st_valid_reg[i-1];
            end
            f1_valid_reg <= st_valid_reg[NSTG];
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_dx_reg    <= p0_dx_next;
            p0_dy_reg    <= p0_dy_next;
            p1_ax_reg    <= p1_ax_next;
            p1_ay_reg    <= p1_ay_next;
            p1_flags_reg <= p1_flags_next;
            p2_ax_reg    <= p1_ax_reg;
            p2_ay_reg    <= p1_ay_reg;
            p2_sqx_reg   <= p2_sqx_next;
            p2_sqy_reg   <= p2_sqy_next;
            p2_flags_reg <= p1_flags_reg;
            st_reg[0]    <= st0_next;
            for (int i = 1; i <= NSTG; i++)
            begin
                st_reg[i] <= st_next[i];
            end
            f1_a_reg     <= f1_a_next;
            f1_dist_reg  <= f1_dist_next;
            f1_flags_reg <= last_st.flags;
            f2_ang_reg   <= f2_ang_next;
            f2_dist_reg  <= f1_dist_reg;
        end
    end

    // ---------------------------------------------------------------- output and skid
    assign take_out = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load        = 1'b0;
        out_from_skid   = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg)
        begin
            // Pipeline is frozen; drain the parked result first.
            if (take_out)
            begin
                out_load        = 1'b1;
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (f2_valid_reg)
        begin
            if (take_out)
            begin
                out_load       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (take_out)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ang_reg  <= out_from_skid ? skid_ang_reg  : f2_ang_reg;
            out_dist_reg <= out_from_skid ? skid_dist_reg : f2_dist_reg;
        end
        if (skid_load)
        begin
            skid_ang_reg  <= f2_ang_reg;
            skid_dist_reg <= f2_dist_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_dist_reg, out_ang_reg});

    // ---------------------------------------------------------------- assertions
    `VAD_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid register holds a result while the output register is empty")
    `VAD_ASSERT_IMP(a_sqrt_rem_bound, clk, rst_n, st_valid_reg[NSTG],
        last_st.rem <= {1'b0, last_st.root, 1'b0},
        "square root remainder exceeds twice the root")
    `VAD_ASSERT_NEXT(a_angle_wrapped, clk, rst_n, adv && f1_valid_reg,
        f2_ang_reg < FULL_CIRCLE, "angle not wrapped below full circle")
    `VAD_ASSERT_NEXT(a_zero_vector_angle, clk, rst_n,
        adv && f1_valid_reg && f1_flags_reg.dx_zero && f1_flags_reg.dy_zero,
        f2_ang_reg == ANG_0, "zero vector did not give angle zero")

endmodule
